>>> src/tfc_pkg.sv
package tfc_pkg;

    localparam int unsigned HDR_LEN   = 8;
    localparam int unsigned CRC_LEN   = 4;
    localparam int unsigned CNT_W     = 17;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;

    localparam int unsigned ADDR_W    = 4;

    localparam logic [31:0] MAGIC_RST   = 32'd0;
    localparam logic [15:0] MAX_VER_RST = 16'd1;
    localparam logic [15:0] MAX_LEN_RST = 16'd1024;

    typedef enum logic [1:0] {
        REG_MAGIC   = 2'd0,
        REG_MAX_VER = 2'd1,
        REG_MAX_LEN = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        V_GOOD      = 3'd0,
        V_SHORT     = 3'd1,
        V_MAGIC     = 3'd2,
        V_VERSION   = 3'd3,
        V_BODY_LONG = 3'd4,
        V_TRUNC     = 3'd5,
        V_CRC       = 3'd6
    } verdict_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_body;
        logic [15:0] body_index;
        logic        done_res;
        verdict_t    verdict;
    } result_t;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            x = (x >> 1) ^ (CRC_POLY & {32{x[0]}});
        end
        return x;
    endfunction

endpackage

>>> src/telemetry_frame_checker_unit.sv
// Accepted s_* words are registered into the output register, or into the skid
// register while output stalls. Throughput: one word per cycle while skid is empty;
// this two-entry buffer keeps s_tready high while one result waits on m_tready.
// Reset (rst_n low, asynchronous): frame state cleared, CRC to all ones,
// configuration registers to their defaults, output buffer empty.
module telemetry_frame_checker_unit
    import tfc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] in_byte
    input  logic              s_tlast,   // in_last
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // [7:0] out_byte, [23:8] body_index, [26:24] verdict
    output logic              m_tuser,   // [0] is_body
    output logic              m_tlast,   // done_res
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [31:0]      magic_cfg_reg;
    logic [15:0]      max_ver_reg;
    logic [15:0]      max_len_reg;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      crc_reg, crc_next;
    logic [31:0]      hmagic_reg, hmagic_next;
    logic [15:0]      hver_reg, hver_next;
    logic [15:0]      hlen_reg, hlen_next;
    logic [31:0]      rcrc_reg, rcrc_next;

    result_t          res;
    result_t          out_reg, skid_reg;
    logic             out_valid_reg, skid_valid_reg;

    logic             accept, pop, cfg_wr;
    reg_idx_t         cfg_idx;
    logic [CNT_W-1:0] off, rel;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite & pready;
    assign cfg_idx  = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        case (cfg_idx)
            REG_MAGIC:   prdata = magic_cfg_reg;
            REG_MAX_VER: prdata = {16'd0, max_ver_reg};
            REG_MAX_LEN: prdata = {16'd0, max_len_reg};
            default:     prdata = 32'd0;
        endcase
    end

    assign s_tready = ~skid_valid_reg;
    assign accept   = s_tvalid & s_tready;
    assign pop      = out_valid_reg & m_tready;

    assign off = count_reg - CNT_W'(HDR_LEN);
    assign rel = off - {1'b0, hlen_reg};

    always_comb
    begin
        crc_next    = crc_reg;
        hmagic_next = hmagic_reg;
        hver_next   = hver_reg;
        hlen_next   = hlen_reg;
        rcrc_next   = rcrc_reg;
        res.out_byte   = s_tdata;
        res.is_body    = 1'b0;
        res.body_index = 16'd0;
        res.done_res   = s_tlast;
        res.verdict    = V_GOOD;

        if (count_reg < CNT_W'(4))
        begin
            hmagic_next[8*count_reg[1:0] +: 8] = s_tdata;
            crc_next = crc_byte(crc_reg, s_tdata);
        end
        else if (count_reg < CNT_W'(6))
        begin
            hver_next[8*count_reg[0] +: 8] = s_tdata;
            crc_next = crc_byte(crc_reg, s_tdata);
        end
        else if (count_reg < CNT_W'(HDR_LEN))
        begin
            hlen_next[8*count_reg[0] +: 8] = s_tdata;
            crc_next = crc_byte(crc_reg, s_tdata);
        end
        else if (count_reg < COUNT_MAX)
        begin
            if (off < {1'b0, hlen_reg})
            begin
                res.is_body    = 1'b1;
                res.body_index = off[15:0];
                crc_next = crc_byte(crc_reg, s_tdata);
            end
            else if (rel < CNT_W'(CRC_LEN))
            begin
                rcrc_next[8*rel[1:0] +: 8] = s_tdata;
            end
        end

        count_next = (count_reg < COUNT_MAX) ? count_reg + CNT_W'(1) : count_reg;

        if (s_tlast)
        begin
            if (count_next < CNT_W'(HDR_LEN + CRC_LEN))
                res.verdict = V_SHORT;
            else if (hmagic_next != magic_cfg_reg)
                res.verdict = V_MAGIC;
            else if (hver_next > max_ver_reg)
                res.verdict = V_VERSION;
            else if (hlen_next > max_len_reg)
                res.verdict = V_BODY_LONG;
            else if ({1'b0, count_next} < (18'(HDR_LEN + CRC_LEN) + {2'd0, hlen_next}))
                res.verdict = V_TRUNC;
            else if (~crc_next != rcrc_next)
                res.verdict = V_CRC;
            else
                res.verdict = V_GOOD;

            count_next  = '0;
            crc_next    = CRC_INIT;
            hmagic_next = 32'd0;
            hver_next   = 16'd0;
            hlen_next   = 16'd0;
            rcrc_next   = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_cfg_reg <= MAGIC_RST;
            max_ver_reg   <= MAX_VER_RST;
            max_len_reg   <= MAX_LEN_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_MAGIC:   magic_cfg_reg <= pwdata;
                REG_MAX_VER: max_ver_reg   <= pwdata[15:0];
                REG_MAX_LEN: max_len_reg   <= pwdata[15:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            crc_reg    <= CRC_INIT;
            hmagic_reg <= 32'd0;
            hver_reg   <= 16'd0;
            hlen_reg   <= 16'd0;
            rcrc_reg   <= 32'd0;
        end
        else if (accept)
        begin
            count_reg  <= count_next;
            crc_reg    <= crc_next;
            hmagic_reg <= hmagic_next;
            hver_reg   <= hver_next;
            hlen_reg   <= hlen_next;
            rcrc_reg   <= rcrc_next;
        end
    end

    // skid_valid_reg blocks accept, so a word only lands in skid when out holds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg  <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= res;
        end
        else if (accept)
        begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.verdict, out_reg.body_index, out_reg.out_byte};
    assign m_tuser  = out_reg.is_body;
    assign m_tlast  = out_reg.done_res;

endmodule

>>> src/tfc_checker.sv
module tfc_checker
    import tfc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [7:0]        s_tdata,
    input logic              s_tlast,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [31:0]       m_tdata,
    input logic              m_tuser,
    input logic              m_tlast
);

    // stalled output word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // input only back-pressured while a word is pending
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("s_tready low with empty output");

    // word taken into an empty output shows up next cycle, byte and last echoed
    a_echo: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=>
            m_tvalid && m_tdata[7:0] == $past(s_tdata) && m_tlast == $past(s_tlast))
        else $error("accepted word not echoed");

    // verdict only on last word
    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[26:24] == V_GOOD)
        else $error("verdict set on non-last word");

    // non-body words carry zero index
    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[23:8] == 16'd0)
        else $error("body index set outside body");

endmodule

bind telemetry_frame_checker_unit tfc_checker u_tfc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
